FILE: rtl/core/nqs_pkg.sv
// Shared constants and types for the n-queens solution counter.
`default_nettype none
package nqs_pkg;

  localparam int MAX_SIZE   = 16;
  localparam int ROW_W      = $clog2(MAX_SIZE);
  localparam int COL_W      = $clog2(MAX_SIZE + 1);
  localparam int DIAG_W     = 2 * MAX_SIZE - 1;
  localparam int DIAG_IDX_W = $clog2(DIAG_W);
  localparam int COUNT_W    = 24;
  localparam int ACC_W      = COUNT_W + ROW_W;
  localparam int SIZE_W     = 5;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [COUNT_W-1:0]   COUNT_MAX      = {COUNT_W{1'b1}};
  localparam logic [SIZE_W-1:0]    BOARD_SIZE_RST = SIZE_W'(8);
  localparam logic [REG_IDX_W-1:0] REG_BOARD_SIZE = REG_IDX_W'(0);

  typedef struct packed {
    logic             start;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] size;
  } srch_cmd_t;

  typedef struct packed {
    logic               done;
    logic [COUNT_W-1:0] count;
  } srch_rsp_t;

endpackage
`default_nettype wire

FILE: rtl/core/nqs_stack_ram.sv
// Queen row stack: one write port, one registered read port.
`default_nettype none
module nqs_stack_ram
  import nqs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [ROW_W-1:0] waddr,
  input  wire logic [ROW_W-1:0] wdata,
  input  wire logic             re,
  input  wire logic [ROW_W-1:0] raddr,
  output logic      [ROW_W-1:0] rdata
);

  logic [ROW_W-1:0] mem [MAX_SIZE];
  logic [ROW_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: rtl/core/nqs_search.sv
// Backtracking search engine: counts placements for one fixed first-column row.
`default_nettype none
module nqs_search
  import nqs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire srch_cmd_t cmd,
  output srch_rsp_t      rsp
);

  typedef enum logic [2:0] {
    SR_IDLE   = 3'b001,
    SR_SEARCH = 3'b010,
    SR_POP    = 3'b100
  } srch_state_t;

  srch_state_t          state_r, state_nxt;
  logic                 done_r, done_nxt;
  logic [MAX_SIZE-1:0]  row_mask_r, row_mask_nxt;
  logic [DIAG_W-1:0]    rise_r, rise_nxt;
  logic [DIAG_W-1:0]    fall_r, fall_nxt;
  logic [COL_W-1:0]     col_r, col_nxt;
  logic [COL_W-1:0]     size_r, size_nxt;
  logic [COL_W-1:0]     next_try_r, next_try_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;

  logic [COL_W-1:0]      fall_off;
  logic [COL_W-1:0]      pcol;
  logic [DIAG_W-1:0]     rise_sh;
  logic [DIAG_W-1:0]     fall_sh;
  logic [MAX_SIZE-1:0]   free;
  logic [ROW_W-1:0]      pick;
  logic                  found;
  logic                  col_full;
  logic                  place;
  logic                  retreat;
  logic [ROW_W-1:0]      prev;
  logic [DIAG_IDX_W-1:0] start_fall_idx;
  logic [DIAG_IDX_W-1:0] put_rise_idx;
  logic [DIAG_IDX_W-1:0] put_fall_idx;
  logic [DIAG_IDX_W-1:0] pop_rise_idx;
  logic [DIAG_IDX_W-1:0] pop_fall_idx;
  logic                  ram_we;
  logic                  ram_re;

  assign fall_off = size_r - col_r - COL_W'(1);
  assign pcol     = col_r - COL_W'(1);
  assign rise_sh  = rise_r >> col_r;
  assign fall_sh  = fall_r >> fall_off;
  assign col_full = (col_r == size_r);

  always_comb begin
    for (int i = 0; i < MAX_SIZE; i++) begin
      free[i] = !row_mask_r[i] && !rise_sh[i] && !fall_sh[i] &&
                (COL_W'(i) < size_r) && (COL_W'(i) >= next_try_r);
    end
  end

  always_comb begin
    pick = '0;
    for (int i = MAX_SIZE - 1; i >= 0; i--) begin
      if (free[i]) begin
        pick = ROW_W'(i);
      end
    end
  end

  assign found   = |free;
  assign place   = (state_r == SR_SEARCH) && !col_full && found;
  assign retreat = (state_r == SR_SEARCH) && (col_full || !found);

  assign start_fall_idx = DIAG_IDX_W'(cmd.row) + DIAG_IDX_W'(cmd.size - COL_W'(1));
  assign put_rise_idx   = DIAG_IDX_W'(pick) + DIAG_IDX_W'(col_r);
  assign put_fall_idx   = DIAG_IDX_W'(pick) + DIAG_IDX_W'(fall_off);
  assign pop_rise_idx   = DIAG_IDX_W'(prev) + DIAG_IDX_W'(pcol);
  assign pop_fall_idx   = DIAG_IDX_W'(prev) + DIAG_IDX_W'(size_r - col_r);

  assign ram_we = place;
  assign ram_re = retreat && (col_r > COL_W'(1));

  nqs_stack_ram u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (col_r[ROW_W-1:0]),
    .wdata (pick),
    .re    (ram_re),
    .raddr (pcol[ROW_W-1:0]),
    .rdata (prev)
  );

  always_comb begin
    state_nxt    = state_r;
    done_nxt     = 1'b0;
    row_mask_nxt = row_mask_r;
    rise_nxt     = rise_r;
    fall_nxt     = fall_r;
    col_nxt      = col_r;
    size_nxt     = size_r;
    next_try_nxt = next_try_r;
    count_nxt    = count_r;
    case (state_r)
      SR_IDLE: begin
        if (cmd.start) begin
          size_nxt     = cmd.size;
          row_mask_nxt = MAX_SIZE'(1) << cmd.row;
          rise_nxt     = DIAG_W'(1) << cmd.row;
          fall_nxt     = DIAG_W'(1) << start_fall_idx;
          col_nxt      = COL_W'(1);
          next_try_nxt = '0;
          count_nxt    = '0;
          state_nxt    = SR_SEARCH;
        end
      end
      SR_SEARCH: begin
        if (col_full && count_r != COUNT_MAX) begin
          count_nxt = count_r + COUNT_W'(1);
        end
        if (place) begin
          row_mask_nxt = row_mask_r | (MAX_SIZE'(1) << pick);
          rise_nxt     = rise_r | (DIAG_W'(1) << put_rise_idx);
          fall_nxt     = fall_r | (DIAG_W'(1) << put_fall_idx);
          col_nxt      = col_r + COL_W'(1);
          next_try_nxt = '0;
        end else if (col_r <= COL_W'(1)) begin
          done_nxt  = 1'b1;
          state_nxt = SR_IDLE;
        end else begin
          state_nxt = SR_POP;
        end
      end
      SR_POP: begin
        row_mask_nxt = row_mask_r & ~(MAX_SIZE'(1) << prev);
        rise_nxt     = rise_r & ~(DIAG_W'(1) << pop_rise_idx);
        fall_nxt     = fall_r & ~(DIAG_W'(1) << pop_fall_idx);
        col_nxt      = pcol;
        next_try_nxt = COL_W'(prev) + COL_W'(1);
        state_nxt    = SR_SEARCH;
      end
      default: begin
        state_nxt = SR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SR_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_mask_r <= row_mask_nxt;
    rise_r     <= rise_nxt;
    fall_r     <= fall_nxt;
    col_r      <= col_nxt;
    size_r     <= size_nxt;
    next_try_r <= next_try_nxt;
    count_r    <= count_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.count = count_r;

endmodule
`default_nettype wire

FILE: rtl/core/nqueens_solution_counter_unit.sv
// Top level of the n-queens solution counter: register port, request sequencing, result.
// One transaction asks for the number of non-attacking queen placements on the board set
// by board_size (clamped to 16), either in total or with the first-column queen in one row.
// The search engine walks the backtracking tree: it places a queen or fails a column in its
// search state and backs up through a separate pop state, since each backtrack reads the
// queen row stack memory through its registered read port. A request runs one search per
// first-column row (one row for a single-row count, ceil(n/2) rows for a total), so the
// time grows steeply with board size. Requests with size 0 or a row outside the board skip
// the search. The block works on one transaction at a time and takes the next while a
// result still waits on out_stall. The stack memory needs no clearing after reset.
`default_nettype none
module nqueens_solution_counter_unit
  import nqs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [3:0]            in_first_row,
  input  wire logic                  in_count_all,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [COUNT_W-1:0]         out_solution_count,
  output logic                       out_bad_request,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  typedef enum logic [3:0] {
    T_IDLE   = 4'b0001,
    T_RUN    = 4'b0010,
    T_WAIT   = 4'b0100,
    T_FINISH = 4'b1000
  } top_state_t;

  top_state_t          state_r, state_nxt;
  logic [SIZE_W-1:0]   board_size_r;
  logic [COL_W-1:0]    size_r, size_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [ROW_W-1:0]    last_r, last_nxt;
  logic                all_r, all_nxt;
  logic                bad_r, bad_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;
  logic                out_bad_r, out_bad_nxt;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  logic [COL_W-1:0]     n_eff;
  logic [COL_W-1:0]     mirror;
  logic [COL_W-1:0]     half_up;
  logic                 middle;
  logic [ACC_W-1:0]     row_add;
  logic                 out_free;
  srch_cmd_t            cmd;
  srch_rsp_t            rsp;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == REG_BOARD_SIZE) ? CFG_DATA_W'(board_size_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_size_r <= BOARD_SIZE_RST;
    end else if (cfg_wr && reg_idx == REG_BOARD_SIZE) begin
      board_size_r <= pwdata[SIZE_W-1:0];
    end
  end

  assign n_eff   = (board_size_r > SIZE_W'(MAX_SIZE)) ? COL_W'(MAX_SIZE) : COL_W'(board_size_r);
  assign mirror  = n_eff - COL_W'(1) - COL_W'(in_first_row);
  assign half_up = (n_eff + COL_W'(1)) >> 1;
  assign middle  = (COL_W'({row_r, 1'b1}) == size_r);
  assign row_add = (all_r && !middle) ? (ACC_W'(rsp.count) << 1) : ACC_W'(rsp.count);
  assign out_free = !out_valid_r || !out_stall;

  assign cmd.start = (state_r == T_RUN);
  assign cmd.row   = row_r;
  assign cmd.size  = size_r;

  nqs_search u_search (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .rsp   (rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    size_nxt      = size_r;
    row_nxt       = row_r;
    last_nxt      = last_r;
    all_nxt       = all_r;
    bad_nxt       = bad_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_count_nxt = out_count_r;
    out_bad_nxt   = out_bad_r;
    case (state_r)
      T_IDLE: begin
        if (in_valid) begin
          size_nxt = n_eff;
          all_nxt  = in_count_all;
          bad_nxt  = 1'b0;
          acc_nxt  = '0;
          if (in_count_all) begin
            if (n_eff == '0) begin
              acc_nxt   = ACC_W'(1);
              state_nxt = T_FINISH;
            end else begin
              row_nxt   = '0;
              last_nxt  = ROW_W'(half_up - COL_W'(1));
              state_nxt = T_RUN;
            end
          end else if (COL_W'(in_first_row) >= n_eff) begin
            bad_nxt   = 1'b1;
            state_nxt = T_FINISH;
          end else begin
            row_nxt   = (COL_W'(in_first_row) < mirror) ? in_first_row : ROW_W'(mirror);
            last_nxt  = (COL_W'(in_first_row) < mirror) ? in_first_row : ROW_W'(mirror);
            state_nxt = T_RUN;
          end
        end
      end
      T_RUN: begin
        state_nxt = T_WAIT;
      end
      T_WAIT: begin
        if (rsp.done) begin
          acc_nxt = acc_r + row_add;
          if (row_r == last_r) begin
            state_nxt = T_FINISH;
          end else begin
            row_nxt   = row_r + ROW_W'(1);
            state_nxt = T_RUN;
          end
        end
      end
      T_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = (acc_r > ACC_W'(COUNT_MAX)) ? COUNT_MAX : acc_r[COUNT_W-1:0];
          out_bad_nxt   = bad_r;
          state_nxt     = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r      <= size_nxt;
    row_r       <= row_nxt;
    last_r      <= last_nxt;
    all_r       <= all_nxt;
    bad_r       <= bad_nxt;
    acc_r       <= acc_nxt;
    out_count_r <= out_count_nxt;
    out_bad_r   <= out_bad_nxt;
  end

  assign in_stall           = (state_r != T_IDLE);
  assign out_valid          = out_valid_r;
  assign out_solution_count = out_count_r;
  assign out_bad_request    = out_bad_r;

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking testbench for the n-queens solution counter: directed and random requests.
`timescale 1ns / 1ps
module tb_top
  import nqs_pkg::*;
;

  localparam int          SETTLE_CYCLES = 64;
  localparam int          HOLD_CYCLES   = 300;
  localparam longint      TIMEOUT_NS    = 64'd240_000_000;

  typedef struct packed {
    logic [3:0] first_row;
    logic       count_all;
  } request_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               bad;
  } tally_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [3:0]            in_first_row = '0;
  logic                  in_count_all = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [COUNT_W-1:0]    out_solution_count;
  logic                  out_bad_request;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  request_t    pending_requests[$];
  tally_t      expected_tallies[$];
  logic [SIZE_W-1:0] board_size_copy = BOARD_SIZE_RST;

  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  bit          pressure_on = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;

  int unsigned mismatches = 0;
  int unsigned n_requests = 0;
  int unsigned n_full = 0;
  int unsigned n_bad = 0;
  int unsigned n_size_writes = 0;
  int unsigned largest_size = 0;

  nqueens_solution_counter_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_first_row      (in_first_row),
    .in_count_all      (in_count_all),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_solution_count(out_solution_count),
    .out_bad_request   (out_bad_request),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #6 clk = ~clk;

  function automatic int unsigned placements_from_row(int unsigned first, int unsigned n);
    logic [MAX_SIZE-1:0] rows_used;
    logic [DIAG_W-1:0]   sum_diag;
    logic [DIAG_W-1:0]   diff_diag;
    int unsigned         queen_at[MAX_SIZE];
    int unsigned         col;
    int unsigned         next_row;
    int unsigned         found;
    int unsigned         r;
    bit                  placed;
    rows_used = '0;
    sum_diag = '0;
    diff_diag = '0;
    rows_used[first] = 1'b1;
    sum_diag[first] = 1'b1;
    diff_diag[first + n - 1] = 1'b1;
    col = 1;
    next_row = 0;
    found = 0;
    forever begin
      placed = 1'b0;
      if (col >= n) begin
        found++;
      end else begin
        for (r = next_row; r < n; r++) begin
          if (!placed && !rows_used[r] && !sum_diag[r + col] && !diff_diag[r + n - 1 - col]) begin
            queen_at[col] = r;
            rows_used[r] = 1'b1;
            sum_diag[r + col] = 1'b1;
            diff_diag[r + n - 1 - col] = 1'b1;
            placed = 1'b1;
          end
        end
      end
      if (placed) begin
        col++;
        next_row = 0;
      end else begin
        if (col <= 1) break;
        col--;
        r = queen_at[col];
        rows_used[r] = 1'b0;
        sum_diag[r + col] = 1'b0;
        diff_diag[r + n - 1 - col] = 1'b0;
        next_row = r + 1;
      end
    end
    return found;
  endfunction

  function automatic tally_t predict_tally(logic [3:0] row, logic all, logic [SIZE_W-1:0] size_reg);
    tally_t      res;
    int unsigned n;
    int unsigned total;
    n = (size_reg > MAX_SIZE) ? MAX_SIZE : 32'(size_reg);
    total = 0;
    res.bad = 1'b0;
    if (all) begin
      if (n == 0) total = 1;
      else for (int unsigned k = 0; k < n; k++) total += placements_from_row(k, n);
    end else if (32'(row) >= n) begin
      res.bad = 1'b1;
    end else begin
      total = placements_from_row(32'(row), n);
    end
    res.count = (total > COUNT_MAX) ? COUNT_MAX : total[COUNT_W-1:0];
    return res;
  endfunction

  // sender: hold a stalled transaction, else idle out the drawn gap, else offer the next one
  always @(negedge clk) begin
    request_t req;
    if (rst_n) begin
      if (in_fire) gap_left = tx_quiet ? 0 : $urandom_range(0, 16);
      if (in_valid && !in_fire) begin
      end else if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pending_requests.size() != 0) begin
        req = pending_requests.pop_front();
        in_first_row <= req.first_row;
        in_count_all <= req.count_all;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: draw a wait per result, plus one long hold-off under pressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_fire) stall_left = rx_quiet ? 0 : $urandom_range(0, 16);
      if (pressure_on && !hold_done) begin
        stall_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    tally_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      out_fire <= out_valid && !out_stall;
      if (in_valid && !in_stall) begin
        want = predict_tally(in_first_row, in_count_all, board_size_copy);
        expected_tallies.push_back(want);
        n_requests++;
        if (in_count_all) n_full++;
        if (want.bad) n_bad++;
      end
      if (out_valid && !out_stall) begin
        if (expected_tallies.size() == 0) begin
          $error("unexpected result: solution_count %0d bad_request %0b",
                 out_solution_count, out_bad_request);
          mismatches++;
        end else begin
          want = expected_tallies.pop_front();
          if (out_solution_count !== want.count) begin
            $error("solution_count: expected %0d, actual %0d", want.count, out_solution_count);
            mismatches++;
          end
          if (out_bad_request !== want.bad) begin
            $error("bad_request: expected %0b, actual %0b", want.bad, out_bad_request);
            mismatches++;
          end
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_valid || expected_tallies.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_board_size(logic [SIZE_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_BOARD_SIZE, 2'b00};
    pwdata <= CFG_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board_size_copy = value;
    n_size_writes++;
    if (32'(value) > largest_size) largest_size = 32'(value);
  endtask

  task automatic start_phase(logic [SIZE_W-1:0] size, bit quiet);
    wait_drained();
    write_board_size(size);
    tx_quiet = quiet;
    rx_quiet = quiet;
  endtask

  task automatic add_request(int unsigned row, bit all);
    request_t req;
    req.first_row = row[3:0];
    req.count_all = all;
    pending_requests.push_back(req);
  endtask

  initial begin
    int unsigned size;
    int unsigned items;
    largest_size = 32'(BOARD_SIZE_RST);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    add_request(0, 1);
    add_request(0, 0);
    add_request(7, 0);
    add_request(3, 0);
    add_request(15, 0);
    add_request(8, 0);
    add_request(15, 1);

    start_phase(0, 0);
    add_request(0, 1);
    add_request(0, 0);

    start_phase(1, 0);
    add_request(0, 1);
    add_request(0, 0);
    add_request(1, 0);

    start_phase(2, 1);
    add_request(0, 1);
    add_request(1, 0);

    start_phase(3, 0);
    add_request(2, 1);

    start_phase(9, 0);
    add_request(8, 0);
    add_request(0, 1);

    start_phase(10, 0);
    add_request(9, 0);
    add_request(5, 0);
    add_request(10, 1);

    // fill the block while the result side holds off
    start_phase(4, 1);
    pressure_on = 1'b1;
    for (int i = 0; i < 12; i++) add_request($urandom_range(0, 5), 1'($urandom_range(0, 1)));

    for (int ph = 0; ph < 10; ph++) begin
      size = (ph == 5) ? 10 : $urandom_range(0, 9);
      start_phase(SIZE_W'(size), $urandom_range(0, 3) == 0);
      items = (size == 10) ? 8 : $urandom_range(6, 8);
      for (int i = 0; i < items; i++) begin
        if (size != 0 && $urandom_range(0, 4) != 0) begin
          add_request($urandom_range(0, size - 1),
                      (size <= 8) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 7) == 0));
        end else begin
          add_request($urandom_range(0, 15), (size <= 8) ? 1'($urandom_range(0, 1)) : 1'b0);
        end
      end
    end

    wait_drained();
    if (expected_tallies.size() != 0) begin
      $error("%0d results never arrived", expected_tallies.size());
      mismatches++;
    end
    $display("Checked %0d requests: %0d full-board counts, %0d rows off the board.",
             n_requests, n_full, n_bad);
    $display("Board sizes up to %0d over %0d size writes, with one long result hold-off.",
             largest_size, n_size_writes);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule
